@@ sv/tsw_pkg.sv @@
package tsw_pkg;

  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned MAX_BURST  = 64;

  localparam logic [10:0] PAYLOAD_CAP    = 11'd1452;
  localparam logic [16:0] STREAM_CAP_MAX = 17'h10000;

  localparam logic [2:0] MODE_WRITE     = 3'd0;
  localparam logic [2:0] MODE_CLOSE     = 3'd1;
  localparam logic [2:0] MODE_ACK       = 3'd2;
  localparam logic [2:0] MODE_TICK      = 3'd3;
  localparam logic [2:0] MODE_EMPTY_SEG = 3'd4;
  localparam logic [2:0] MODE_FILL      = 3'd5;

  localparam logic [1:0] REG_INIT_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_INIT_SEQ     = 2'd1;
  localparam logic [1:0] REG_STREAM_CAP   = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_CLOSE,
    S_EMPTY_SEG,
    S_NONE,
    S_ACK0,
    S_ACK1,
    S_ACK_CMP,
    S_ACK_WAIT,
    S_TICK0,
    S_TICK1,
    S_FILL_CHK,
    S_FILL_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OK_NONE,
    OK_WRITE,
    OK_SEG,
    OK_RETX,
    OK_EMPTY_SEG
  } out_kind_t;

  typedef struct packed {
    logic      latch_in;
    logic      ack_calc_d;
    logic      ack_commit;
    logic      retire;
    logic      tick_timer;
    logic      tick_fire;
    logic      fill_step;
    logic      close_input;
    logic      write_commit;
    logic      out_load;
    out_kind_t out_kind;
    logic      out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_can_load;
    logic ack_valid;
    logic retire_ok;
    logic tick_fire_ok;
    logic fill_go;
    logic seg_fin;
  } dp_stat_t;

endpackage

@@ sv/tsw_ctrl.sv @@
module tsw_ctrl
  import tsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_mode,
  output logic       in_stall,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_WRITE:     state_nxt = S_WRITE;
            MODE_CLOSE:     state_nxt = S_CLOSE;
            MODE_ACK:       state_nxt = S_ACK0;
            MODE_TICK:      state_nxt = S_TICK0;
            MODE_EMPTY_SEG: state_nxt = S_EMPTY_SEG;
            MODE_FILL:      state_nxt = S_FILL_CHK;
            default:        state_nxt = S_NONE;
          endcase
        end
      end
      S_WRITE, S_CLOSE, S_EMPTY_SEG, S_NONE, S_TICK1: begin
        if (stat.out_can_load) state_nxt = S_IDLE;
      end
      S_ACK0:     state_nxt = S_ACK1;
      S_ACK1:     state_nxt = stat.ack_valid ? S_ACK_CMP : S_NONE;
      S_ACK_CMP:  state_nxt = stat.retire_ok ? S_ACK_WAIT : S_FILL_CHK;
      S_ACK_WAIT: state_nxt = S_ACK_CMP;
      S_TICK0:    state_nxt = S_TICK1;
      S_FILL_CHK: state_nxt = stat.fill_go ? S_FILL_EMIT : S_NONE;
      S_FILL_EMIT: begin
        if (stat.out_can_load) begin
          state_nxt = (stat.fill_go && !stat.seg_fin) ? S_FILL_CHK : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.out_kind = OK_NONE;
    case (state_r)
      S_IDLE: cmd.latch_in = in_valid;
      S_WRITE: begin
        cmd.write_commit = stat.out_can_load;
        cmd.out_load     = stat.out_can_load;
        cmd.out_kind     = OK_WRITE;
        cmd.out_last     = 1'b1;
      end
      S_CLOSE: begin
        cmd.close_input = stat.out_can_load;
        cmd.out_load    = stat.out_can_load;
        cmd.out_last    = 1'b1;
      end
      S_EMPTY_SEG: begin
        cmd.out_load = stat.out_can_load;
        cmd.out_kind = OK_EMPTY_SEG;
        cmd.out_last = 1'b1;
      end
      S_NONE: begin
        cmd.out_load = stat.out_can_load;
        cmd.out_last = 1'b1;
      end
      S_ACK0:    cmd.ack_calc_d = 1'b1;
      S_ACK1:    cmd.ack_commit = stat.ack_valid;
      S_ACK_CMP: cmd.retire     = stat.retire_ok;
      S_TICK0:   cmd.tick_timer = 1'b1;
      S_TICK1: begin
        cmd.tick_fire = stat.out_can_load && stat.tick_fire_ok;
        cmd.out_load  = stat.out_can_load;
        cmd.out_kind  = stat.tick_fire_ok ? OK_RETX : OK_NONE;
        cmd.out_last  = 1'b1;
      end
      S_FILL_CHK: cmd.fill_step = stat.fill_go;
      S_FILL_EMIT: begin
        cmd.out_load = stat.out_can_load;
        cmd.out_kind = OK_SEG;
        cmd.out_last = !(stat.fill_go && !stat.seg_fin);
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ sv/tsw_dp.sv @@
module tsw_dp
  import tsw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [16:0] in_byte_count,
  input  logic [31:0] in_ack_number,
  input  logic [15:0] in_peer_window,
  input  logic [15:0] in_elapsed_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_segment,
  output logic [31:0] out_seg_seqno,
  output logic [10:0] out_seg_length,
  output logic        out_seg_syn,
  output logic        out_seg_fin,
  output logic        out_is_retransmit,
  output logic [16:0] out_accepted_bytes,
  output logic [17:0] out_in_flight,
  output logic [7:0]  out_retx_in_a_row,
  output logic        out_last_result
);

  localparam logic [RING_AW:0] DEPTH_C = (RING_AW+1)'(RING_DEPTH);
  localparam logic [6:0]       BURST_C = 7'(MAX_BURST);

  logic [15:0] to_cfg_r;
  logic [31:0] iseq_r;
  logic [16:0] cap_cfg_r;
  logic [10:0] mp_cfg_r;

  logic [63:0]        next_r, next_nxt;
  logic [17:0]        flight_r, flight_nxt;
  logic               syn_done_r, syn_done_nxt;
  logic               fin_done_r, fin_done_nxt;
  logic [15:0]        win_r, win_nxt;
  logic [31:0]        tmo_r, tmo_nxt;
  logic [31:0]        timer_r, timer_nxt;
  logic [7:0]         retx_r, retx_nxt;
  logic [16:0]        buf_r, buf_nxt;
  logic               closed_r, closed_nxt;
  logic [RING_AW-1:0] head_r, head_nxt;
  logic [RING_AW:0]   used_r, used_nxt;
  logic [6:0]         burst_r, burst_nxt;
  logic [17:0]        cov_r, cov_nxt;

  logic [16:0] bc_r;
  logic [31:0] ackno_r;
  logic [15:0] pw_r;
  logic [15:0] el_r;
  logic [31:0] d_r;

  logic [31:0] seg_seq_r;
  logic [10:0] seg_len_r;
  logic        seg_syn_r, seg_fin_r;

  logic [44:0] ring_mem [RING_DEPTH];
  logic [44:0] rd_r;
  logic [RING_AW-1:0] slot;
  logic [31:0] wrap_seq;

  logic        out_valid_r;

  logic [17:0] win18, space, avail;
  logic [10:0] mp, p1, pay;
  logic [16:0] buf_after;
  logic        syn, fin;
  logic [18:0] fin_sum;
  logic [11:0] total;
  logic        fill_go;

  logic [32:0] back, gap;
  logic        ack_valid;
  logic [17:0] cov_calc;
  logic [11:0] rd_total;

  logic [32:0] timer_sum;

  logic [16:0] cap, room, acc;

  assign wrap_seq = next_r[31:0] + iseq_r;
  assign slot     = head_r + used_r[RING_AW-1:0];

  always_comb begin
    win18     = (win_r == 16'd0) ? 18'd1 : {2'b00, win_r};
    mp        = (mp_cfg_r > PAYLOAD_CAP) ? PAYLOAD_CAP : mp_cfg_r;
    syn       = !syn_done_r;
    space     = win18 - flight_r;
    avail     = space - {17'd0, syn};
    p1        = (avail < {7'd0, mp}) ? avail[10:0] : mp;
    pay       = ({6'd0, p1} < buf_r) ? p1 : buf_r[10:0];
    buf_after = buf_r - {6'd0, pay};
    fin_sum   = {8'd0, pay} + {18'd0, syn} + {1'b0, flight_r};
    fin       = closed_r && (buf_after == 17'd0) && !fin_done_r && (fin_sum < {1'b0, win18});
    total     = {1'b0, pay} + {11'd0, syn} + {11'd0, fin};
    fill_go   = (win18 > flight_r) && (burst_r < BURST_C) && (used_r < DEPTH_C)
                && (total != 12'd0);
  end

  always_comb begin
    back      = 33'h1_0000_0000 - {1'b0, d_r};
    ack_valid = (d_r == 32'd0) ||
                (d_r[31] && ((next_r[63:32] != 32'd0) || ({1'b0, next_r[31:0]} >= back)));
    gap       = (d_r == 32'd0) ? 33'd0 : back;
    cov_calc  = ({15'd0, flight_r} >= gap) ? (flight_r - gap[17:0]) : 18'd0;
    rd_total  = {1'b0, rd_r[12:2]} + {11'd0, rd_r[1]} + {11'd0, rd_r[0]};
  end

  assign timer_sum = {1'b0, timer_r} + {17'd0, el_r};

  always_comb begin
    cap  = (cap_cfg_r > STREAM_CAP_MAX) ? STREAM_CAP_MAX : cap_cfg_r;
    room = (cap > buf_r) ? (cap - buf_r) : 17'd0;
    acc  = (bc_r < room) ? bc_r : room;
  end

  always_comb begin
    stat.out_can_load = !out_valid_r || !out_stall;
    stat.ack_valid    = ack_valid;
    stat.retire_ok    = (used_r != '0) && ({6'd0, rd_total} <= cov_r);
    stat.tick_fire_ok = (used_r != '0) && (timer_r >= tmo_r);
    stat.fill_go      = fill_go;
    stat.seg_fin      = seg_fin_r;
  end

  always_comb begin
    next_nxt     = next_r;
    flight_nxt   = flight_r;
    syn_done_nxt = syn_done_r;
    fin_done_nxt = fin_done_r;
    win_nxt      = win_r;
    tmo_nxt      = tmo_r;
    timer_nxt    = timer_r;
    retx_nxt     = retx_r;
    buf_nxt      = buf_r;
    closed_nxt   = closed_r;
    head_nxt     = head_r;
    used_nxt     = used_r;
    burst_nxt    = burst_r;
    cov_nxt      = cov_r;
    if (cmd.latch_in) burst_nxt = 7'd0;
    if (cmd.write_commit) buf_nxt = buf_r + acc;
    if (cmd.close_input) closed_nxt = 1'b1;
    if (cmd.ack_commit) begin
      cov_nxt  = cov_calc;
      retx_nxt = 8'd0;
      win_nxt  = pw_r;
    end
    if (cmd.retire) begin
      cov_nxt    = cov_r - {6'd0, rd_total};
      flight_nxt = flight_r - {6'd0, rd_total};
      head_nxt   = head_r + 1'b1;
      used_nxt   = used_r - 1'b1;
      tmo_nxt    = {16'd0, to_cfg_r};
      timer_nxt  = 32'd0;
    end
    if (cmd.tick_timer) timer_nxt = timer_sum[32] ? 32'hFFFF_FFFF : timer_sum[31:0];
    if (cmd.tick_fire) begin
      if (win_r != 16'd0) tmo_nxt = tmo_r[31] ? 32'hFFFF_FFFF : {tmo_r[30:0], 1'b0};
      timer_nxt = 32'd0;
      retx_nxt  = (retx_r == 8'hFF) ? 8'hFF : retx_r + 8'd1;
    end
    if (cmd.fill_step) begin
      if (used_r == '0) begin
        tmo_nxt   = {16'd0, to_cfg_r};
        timer_nxt = 32'd0;
      end
      used_nxt     = used_r + 1'b1;
      flight_nxt   = flight_r + {6'd0, total};
      next_nxt     = next_r + {52'd0, total};
      buf_nxt      = buf_after;
      syn_done_nxt = 1'b1;
      fin_done_nxt = fin_done_r | fin;
      burst_nxt    = burst_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      to_cfg_r    <= 16'd1000;
      iseq_r      <= 32'd0;
      cap_cfg_r   <= 17'd64000;
      mp_cfg_r    <= 11'd1452;
      next_r      <= 64'd0;
      flight_r    <= 18'd0;
      syn_done_r  <= 1'b0;
      fin_done_r  <= 1'b0;
      win_r       <= 16'd0;
      tmo_r       <= 32'd1000;
      timer_r     <= 32'd0;
      retx_r      <= 8'd0;
      buf_r       <= 17'd0;
      closed_r    <= 1'b0;
      head_r      <= '0;
      used_r      <= '0;
      burst_r     <= 7'd0;
      cov_r       <= 18'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_INIT_TIMEOUT: to_cfg_r  <= cfg_data[15:0];
          REG_INIT_SEQ:     iseq_r    <= cfg_data;
          REG_STREAM_CAP:   cap_cfg_r <= cfg_data[16:0];
          REG_MAX_PAYLOAD:  mp_cfg_r  <= cfg_data[10:0];
          default: ;
        endcase
      end
      next_r     <= next_nxt;
      flight_r   <= flight_nxt;
      syn_done_r <= syn_done_nxt;
      fin_done_r <= fin_done_nxt;
      win_r      <= win_nxt;
      tmo_r      <= tmo_nxt;
      timer_r    <= timer_nxt;
      retx_r     <= retx_nxt;
      buf_r      <= buf_nxt;
      closed_r   <= closed_nxt;
      head_r     <= head_nxt;
      used_r     <= used_nxt;
      burst_r    <= burst_nxt;
      cov_r      <= cov_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      bc_r    <= in_byte_count;
      ackno_r <= in_ack_number;
      pw_r    <= in_peer_window;
      el_r    <= in_elapsed_ms;
    end
    if (cmd.ack_calc_d) d_r <= ackno_r - iseq_r - next_r[31:0];
    if (cmd.fill_step) begin
      ring_mem[slot] <= {wrap_seq, pay, syn, fin};
      seg_seq_r      <= wrap_seq;
      seg_len_r      <= pay;
      seg_syn_r      <= syn;
      seg_fin_r      <= fin;
    end
    rd_r <= ring_mem[head_r];
    if (cmd.out_load) begin
      out_has_segment    <= 1'b0;
      out_seg_seqno      <= 32'd0;
      out_seg_length     <= 11'd0;
      out_seg_syn        <= 1'b0;
      out_seg_fin        <= 1'b0;
      out_is_retransmit  <= 1'b0;
      out_accepted_bytes <= 17'd0;
      out_in_flight      <= flight_nxt;
      out_retx_in_a_row  <= retx_nxt;
      out_last_result    <= cmd.out_last;
      case (cmd.out_kind)
        OK_WRITE: out_accepted_bytes <= acc;
        OK_SEG: begin
          out_has_segment <= 1'b1;
          out_seg_seqno   <= seg_seq_r;
          out_seg_length  <= seg_len_r;
          out_seg_syn     <= seg_syn_r;
          out_seg_fin     <= seg_fin_r;
        end
        OK_RETX: begin
          out_has_segment   <= 1'b1;
          out_seg_seqno     <= rd_r[44:13];
          out_seg_length    <= rd_r[12:2];
          out_seg_syn       <= rd_r[1];
          out_seg_fin       <= rd_r[0];
          out_is_retransmit <= 1'b1;
        end
        OK_EMPTY_SEG: begin
          out_has_segment <= 1'b1;
          out_seg_seqno   <= wrap_seq;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/tcp_sender_window_retransmit_core.sv @@
// A write, close, empty segment or unknown mode moves to its own state, which registers
// its result if the output can load; ticks pass TICK0, TICK1; rejected acks ACK0, ACK1, NONE.
// An accepted ack passes ACK0, ACK1, ACK_CMP, an ACK_WAIT per retired segment, then the fill.
// The window fill emits each segment through a check state and an emit state.
// One item is processed at a time; the input stalls until its last result is registered.
// Reset is synchronous and active low; it restores the control registers and empties the ring.
module tcp_sender_window_retransmit_core
  import tsw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [16:0] in_byte_count,
  input  logic [31:0] in_ack_number,
  input  logic [15:0] in_peer_window,
  input  logic [15:0] in_elapsed_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_segment,
  output logic [31:0] out_seg_seqno,
  output logic [10:0] out_seg_length,
  output logic        out_seg_syn,
  output logic        out_seg_fin,
  output logic        out_is_retransmit,
  output logic [16:0] out_accepted_bytes,
  output logic [17:0] out_in_flight,
  output logic [7:0]  out_retx_in_a_row,
  output logic        out_last_result
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  tsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tsw_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_byte_count      (in_byte_count),
    .in_ack_number      (in_ack_number),
    .in_peer_window     (in_peer_window),
    .in_elapsed_ms      (in_elapsed_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_has_segment    (out_has_segment),
    .out_seg_seqno      (out_seg_seqno),
    .out_seg_length     (out_seg_length),
    .out_seg_syn        (out_seg_syn),
    .out_seg_fin        (out_seg_fin),
    .out_is_retransmit  (out_is_retransmit),
    .out_accepted_bytes (out_accepted_bytes),
    .out_in_flight      (out_in_flight),
    .out_retx_in_a_row  (out_retx_in_a_row),
    .out_last_result    (out_last_result)
  );

endmodule
